>>> src/rpn_pkg.sv
package rpn_pkg;

  localparam int DATA_W = 32;
  localparam int STACK_DEPTH_DEF = 128;
  localparam int FRACTION_BITS_DEF = 16;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_MUL     = 3'd2,
    CMD_NEG     = 3'd3,
    CMD_DIV     = 3'd4,
    CMD_MOD     = 3'd5,
    CMD_SHOW    = 3'd6,
    CMD_UNKNOWN = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ZERODIV = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_NEG,
    OP_MUL,
    OP_MULSAT,
    OP_DIVQ,
    OP_MODR
  } op_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [DATA_W-1:0]  operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  result_value;
    status_t                   status;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    pop;
    logic    pop_a;
    logic    cap;
    logic    push;
    logic    top_rd;
    logic    top_cap;
    logic    show;
    logic    note;
    status_t note_code;
    op_t     op;
    logic    div_load;
    logic    div_mod;
  } dp_cmd_t;

  typedef struct packed {
    logic b_zero;
    logic ib_zero;
    logic div_busy;
  } dp_stat_t;

endpackage

>>> src/rpn_ram.sv
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/rpn_div.sv
module rpn_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt;
  logic          run;
  logic [VW-1:0] dvsr;
  logic [VW:0]   shifted;
  logic [VW:0]   diff;
  logic          ge;

  assign shifted = {remainder, quotient[DW-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign ge      = shifted >= {1'b0, dvsr};
  assign busy    = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (load) begin
      run <= 1'b1;
      cnt <= CW'(DW);
    end else if (run) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quotient  <= dividend;
      remainder <= '0;
      dvsr      <= divisor;
    end else if (run) begin
      if (ge) begin
        remainder <= diff[VW-1:0];
        quotient  <= {quotient[DW-2:0], 1'b1};
      end else begin
        remainder <= shifted[VW-1:0];
        quotient  <= {quotient[DW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> src/rpn_dp.sv
module rpn_dp
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] operand,
  input  dp_cmd_t                  ctl,
  output dp_stat_t                 stat,
  output out_item_t                result
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int DW = DATA_W + FRACTION_BITS;
  localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic [DATA_W-1:0] sat_mag(input logic [63:0] m, input logic neg);
    logic [DATA_W-1:0] r;
    if (neg) begin
      r = (m > 64'(SMIN)) ? SMIN : DATA_W'(0) - m[DATA_W-1:0];
    end else begin
      r = (m > 64'(SMAX)) ? SMAX : m[DATA_W-1:0];
    end
    return r;
  endfunction

  logic [PW-1:0]     sp;
  logic [PW-1:0]     sp_m1;
  logic              pop_hit;
  logic              top_hit;
  logic              full;
  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] out_val;
  status_t           status;
  logic [63:0]       prod;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  logic [DATA_W-1:0] ia;
  logic [DATA_W-1:0] ib;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] rd_data;
  logic              we;
  logic              re;
  logic [DW-1:0]     dvd;
  logic [DATA_W-1:0] dvs;
  logic [DW-1:0]     quo;
  logic [DATA_W-1:0] rem;
  logic              div_busy;

  assign sp_m1 = sp - 1'b1;
  assign full  = sp >= PW'(STACK_DEPTH);
  assign mag_a = a[DATA_W-1] ? DATA_W'(0) - a : a;
  assign mag_b = b[DATA_W-1] ? DATA_W'(0) - b : b;
  assign ia    = mag_a >> FRACTION_BITS;
  assign ib    = mag_b >> FRACTION_BITS;
  assign sum   = {a[DATA_W-1], a} + {b[DATA_W-1], b};
  assign we    = ctl.push && !full;
  assign re    = (ctl.pop || ctl.top_rd) && (sp != '0);
  assign dvd   = ctl.div_mod ? DW'(ia) : DW'(mag_a) << FRACTION_BITS;
  assign dvs   = ctl.div_mod ? ib : mag_b;

  assign stat = {b == '0, ib == '0, div_busy};

  assign result = {out_val, status};

  rpn_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(sp[AW-1:0]),
    .wdata(res),
    .re   (re),
    .raddr(sp_m1[AW-1:0]),
    .rdata(rd_data)
  );

  rpn_div #(
    .DW(DW),
    .VW(DATA_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (ctl.div_load),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .quotient (quo),
    .remainder(rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      pop_hit <= 1'b0;
      top_hit <= 1'b0;
      status  <= ST_OK;
    end else begin
      if (ctl.pop) begin
        pop_hit <= sp != '0;
        if (sp != '0) begin
          sp <= sp_m1;
        end
      end
      if (ctl.top_rd) begin
        top_hit <= sp != '0;
      end
      if (we) begin
        sp <= sp + 1'b1;
      end
      if (ctl.load) begin
        status <= ctl.note ? ctl.note_code : ST_OK;
      end else if (status == ST_OK) begin
        if (ctl.pop && sp == '0) begin
          status <= ST_EMPTY;
        end else if (ctl.push && full) begin
          status <= ST_FULL;
        end else if (ctl.note) begin
          status <= ctl.note_code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      if (ctl.pop_a) begin
        a <= pop_hit ? rd_data : '0;
      end else begin
        b <= pop_hit ? rd_data : '0;
      end
    end
    if (ctl.load) begin
      res <= operand;
    end else begin
      case (ctl.op)
        OP_ADD: begin
          if (sum[DATA_W] != sum[DATA_W-1]) begin
            res <= sum[DATA_W] ? SMIN : SMAX;
          end else begin
            res <= sum[DATA_W-1:0];
          end
        end
        OP_NEG:    res <= (a == SMIN) ? SMAX : DATA_W'(0) - a;
        OP_MUL:    prod <= mag_a * mag_b;
        OP_MULSAT: res <= sat_mag(prod >> FRACTION_BITS, a[DATA_W-1] ^ b[DATA_W-1]);
        OP_DIVQ:   res <= sat_mag(64'(quo), a[DATA_W-1] ^ b[DATA_W-1]);
        OP_MODR:   res <= sat_mag(64'(rem) << FRACTION_BITS, a[DATA_W-1]);
        default: begin
        end
      endcase
    end
    if (ctl.top_cap) begin
      out_val <= top_hit ? rd_data : '0;
    end else if (ctl.show) begin
      out_val <= a;
    end
  end

endmodule

>>> src/rpn_ctrl.sv
module rpn_ctrl
  import rpn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cmd_t     command,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl,
  output logic     busy,
  output logic     done
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_POP_B,
    S_CAP_B,
    S_CHK_B,
    S_POP_A,
    S_CAP_A,
    S_EXEC,
    S_MUL_SAT,
    S_DIV_LD,
    S_DIV_RUN,
    S_DIV_FIN,
    S_SHOW,
    S_TOP,
    S_TOP_CAP,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  cmd_t   cmd;

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.note_code = ST_OK;
    ctl.op        = OP_NONE;
    ctl.div_mod   = cmd == CMD_MOD;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          case (command)
            CMD_PUSH: state_next = S_PUSH;
            CMD_NEG, CMD_SHOW: state_next = S_POP_A;
            CMD_ADD, CMD_MUL, CMD_DIV, CMD_MOD: state_next = S_POP_B;
            default: begin
              ctl.note      = 1'b1;
              ctl.note_code = ST_UNKNOWN;
              state_next    = S_TOP;
            end
          endcase
        end
      end
      S_PUSH: begin
        ctl.push   = 1'b1;
        state_next = S_TOP;
      end
      S_POP_B: begin
        ctl.pop    = 1'b1;
        state_next = S_CAP_B;
      end
      S_CAP_B: begin
        ctl.cap    = 1'b1;
        state_next = (cmd inside {CMD_DIV, CMD_MOD}) ? S_CHK_B : S_POP_A;
      end
      S_CHK_B: begin
        if ((cmd == CMD_DIV && stat.b_zero) || (cmd == CMD_MOD && stat.ib_zero)) begin
          ctl.note      = 1'b1;
          ctl.note_code = ST_ZERODIV;
          state_next    = S_TOP;
        end else begin
          state_next = S_POP_A;
        end
      end
      S_POP_A: begin
        ctl.pop    = 1'b1;
        ctl.pop_a  = 1'b1;
        state_next = S_CAP_A;
      end
      S_CAP_A: begin
        ctl.cap   = 1'b1;
        ctl.pop_a = 1'b1;
        case (cmd)
          CMD_SHOW: state_next = S_SHOW;
          CMD_DIV, CMD_MOD: state_next = S_DIV_LD;
          default: state_next = S_EXEC;
        endcase
      end
      S_EXEC: begin
        case (cmd)
          CMD_ADD: begin
            ctl.op     = OP_ADD;
            state_next = S_PUSH;
          end
          CMD_MUL: begin
            ctl.op     = OP_MUL;
            state_next = S_MUL_SAT;
          end
          default: begin
            ctl.op     = OP_NEG;
            state_next = S_PUSH;
          end
        endcase
      end
      S_MUL_SAT: begin
        ctl.op     = OP_MULSAT;
        state_next = S_PUSH;
      end
      S_DIV_LD: begin
        ctl.div_load = 1'b1;
        state_next   = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (!stat.div_busy) begin
          state_next = S_DIV_FIN;
        end
      end
      S_DIV_FIN: begin
        ctl.op     = (cmd == CMD_MOD) ? OP_MODR : OP_DIVQ;
        state_next = S_PUSH;
      end
      S_SHOW: begin
        ctl.show   = 1'b1;
        state_next = S_DONE;
      end
      S_TOP: begin
        ctl.top_rd = 1'b1;
        state_next = S_TOP_CAP;
      end
      S_TOP_CAP: begin
        ctl.top_cap = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      cmd   <= CMD_PUSH;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
      done  <= state_next == S_DONE;
      if (state == S_IDLE && start) begin
        cmd <= command;
      end
    end
  end

endmodule

>>> src/rpn_stack_calculator_top.sv
// One item at a time: busy stays high from acceptance until the result strobe.
// Divide and modulo on a zero divisor end early; otherwise the result waits on the divider,
// which yields one quotient bit per cycle. Values are Q16.16 at the default FRACTION_BITS.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Reset empties the stack (pointer to zero); stack memory is not cleared.
module rpn_stack_calculator_top
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  cmd_item,
  output logic      done,
  output out_item_t result
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  rpn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(cmd_item.command),
    .stat   (stat),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done)
  );

  rpn_dp #(
    .STACK_DEPTH  (STACK_DEPTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .operand(cmd_item.operand_value),
    .ctl    (ctl),
    .stat   (stat),
    .result (result)
  );

endmodule

>>> verif/rpn_stack_calculator_top_tb.sv
module rpn_stack_calculator_top_tb;
  import rpn_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam logic signed [31:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_VAL = 32'sh0001_0000;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
  localparam int GEN = 1;
  localparam int CHK = 0;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  cmd_item = '0;
  logic      done;
  out_item_t result;

  in_item_t  pending_q[$];
  out_item_t expected_q[$];
  int        fail_count = 0;
  bit        have_item = 1'b0;
  int        idle_left = 0;
  out_item_t want;

  logic signed [31:0] stack_mem [2][DEPTH];
  int unsigned        stack_cnt [2] = '{0, 0};
  status_t            fault [2];

  rpn_stack_calculator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd_item (cmd_item),
    .done     (done),
    .result   (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void raise_fault(int s, status_t code);
    if (fault[s] == ST_OK) fault[s] = code;
  endfunction

  function automatic logic signed [31:0] pop_entry(int s);
    if (stack_cnt[s] > 0) begin
      stack_cnt[s]--;
      return stack_mem[s][stack_cnt[s]];
    end
    raise_fault(s, ST_EMPTY);
    return '0;
  endfunction

  function automatic void push_entry(int s, logic signed [31:0] v);
    if (stack_cnt[s] < DEPTH) begin
      stack_mem[s][stack_cnt[s]] = v;
      stack_cnt[s]++;
    end else begin
      raise_fault(s, ST_FULL);
    end
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > SAT_HI) return MAX_VAL;
    if (v < SAT_LO) return MIN_VAL;
    return v[31:0];
  endfunction

  function automatic logic [63:0] magnitude(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic signed [63:0] apply_sign(logic [63:0] m, logic neg);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // one command on stack copy s; returns the result item it shows
  function automatic out_item_t calc_step(int s, in_item_t it);
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    logic signed [31:0] shown;
    logic signed [63:0] wide;
    logic [63:0]        m;
    logic [63:0]        ir;
    logic               was_shown;
    out_item_t          r;
    fault[s] = ST_OK;
    was_shown = 1'b0;
    shown = '0;
    case (it.command)
      CMD_PUSH: push_entry(s, it.operand_value);
      CMD_ADD: begin
        rhs = pop_entry(s);
        lhs = pop_entry(s);
        wide = lhs;
        wide = wide + rhs;
        push_entry(s, clamp32(wide));
      end
      CMD_MUL: begin
        rhs = pop_entry(s);
        lhs = pop_entry(s);
        m = (magnitude(lhs) * magnitude(rhs)) >> FRAC;
        push_entry(s, clamp32(apply_sign(m, lhs[31] ^ rhs[31])));
      end
      CMD_NEG: begin
        lhs = pop_entry(s);
        wide = lhs;
        push_entry(s, clamp32(-wide));
      end
      CMD_DIV: begin
        rhs = pop_entry(s);
        if (rhs == 0) begin
          raise_fault(s, ST_ZERODIV);
        end else begin
          lhs = pop_entry(s);
          m = (magnitude(lhs) << FRAC) / magnitude(rhs);
          push_entry(s, clamp32(apply_sign(m, lhs[31] ^ rhs[31])));
        end
      end
      CMD_MOD: begin
        rhs = pop_entry(s);
        ir = magnitude(rhs) >> FRAC;
        if (ir == 0) begin
          raise_fault(s, ST_ZERODIV);
        end else begin
          lhs = pop_entry(s);
          m = ((magnitude(lhs) >> FRAC) % ir) << FRAC;
          push_entry(s, clamp32(apply_sign(m, lhs[31])));
        end
      end
      CMD_SHOW: begin
        shown = pop_entry(s);
        was_shown = 1'b1;
      end
      default: raise_fault(s, ST_UNKNOWN);
    endcase
    if (!was_shown) shown = (stack_cnt[s] > 0) ? stack_mem[s][stack_cnt[s] - 1] : '0;
    r.result_value = shown;
    r.status = fault[s];
    return r;
  endfunction

  function automatic void queue_item(cmd_t c, logic signed [31:0] v);
    in_item_t it;
    it.command = c;
    it.operand_value = v;
    pending_q.push_back(it);
    void'(calc_step(GEN, it));
  endfunction

  function automatic logic signed [31:0] pick_value();
    int v;
    v = $urandom_range(0, 65535);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1, 2: return ($signed($urandom_range(0, 400)) - 200) * 65536 + v;
      3: begin
        case ($urandom_range(0, 7))
          0: return '0;
          1: return MAX_VAL;
          2: return MIN_VAL;
          3: return ONE_VAL;
          4: return -ONE_VAL;
          5: return 32'sd1;
          6: return -32'sd1;
          default: return ONE_VAL * 2;
        endcase
      end
      4: return $urandom_range(0, 1) ? -v : v;
      default: return {($urandom_range(0, 1) ? 2'b01 : 2'b10), 30'($urandom())};
    endcase
  endfunction

  function automatic cmd_t pick_op();
    case ($urandom_range(0, 4))
      0: return CMD_ADD;
      1: return CMD_MUL;
      2: return CMD_NEG;
      3: return CMD_DIV;
      default: return CMD_MOD;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(calc_step(CHK, cmd_item));
        have_item = 1'b0;
      end
      if (!have_item && pending_q.size() > 0) begin
        cmd_item <= pending_q.pop_front();
        have_item = 1'b1;
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (have_item && pending_q.size() > 40 && $urandom_range(0, 6) == 0) begin
        idle_left = $urandom_range(0, 3);
        start <= 1'b0;
      end else begin
        start <= have_item;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h/%0d", $time,
                 result.result_value, result.status);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (result.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, result.result_value);
          fail_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   result.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned n_rand;
    int          extra;
    bit          filled;

    queue_item(CMD_SHOW, 32'sh1234_5678);
    queue_item(CMD_ADD, '0);
    queue_item(CMD_DIV, '0);
    queue_item(CMD_MOD, '1);
    queue_item(CMD_NEG, '0);
    queue_item(CMD_SHOW, '0);
    queue_item(CMD_PUSH, MIN_VAL);
    queue_item(CMD_NEG, '0);
    queue_item(CMD_PUSH, MAX_VAL);
    queue_item(CMD_ADD, '0);
    queue_item(CMD_PUSH, MIN_VAL);
    queue_item(CMD_PUSH, MIN_VAL);
    queue_item(CMD_ADD, '0);
    queue_item(CMD_MUL, '0);
    queue_item(CMD_PUSH, '0);
    queue_item(CMD_DIV, '0);
    queue_item(CMD_PUSH, 32'sh0000_8000);
    queue_item(CMD_DIV, '0);
    queue_item(CMD_PUSH, 32'sh0000_8000);
    queue_item(CMD_MOD, '0);
    queue_item(CMD_PUSH, 32'sh0002_8000);
    queue_item(CMD_MOD, '0);
    queue_item(CMD_PUSH, -32'sh0007_8000);
    queue_item(CMD_PUSH, 32'sh0002_0000);
    queue_item(CMD_MOD, '0);
    queue_item(CMD_PUSH, 32'sh0001_8000);
    queue_item(CMD_MUL, '0);
    queue_item(CMD_UNKNOWN, $urandom());
    queue_item(CMD_SHOW, '0);
    queue_item(CMD_SHOW, '0);

    n_rand = 0;
    filled = 1'b0;
    while (n_rand < 400) begin
      if (!filled && n_rand >= 60) begin
        while (stack_cnt[GEN] < DEPTH) begin
          queue_item(CMD_PUSH, pick_value());
          n_rand++;
        end
        repeat ($urandom_range(1, 3)) begin
          queue_item(CMD_PUSH, pick_value());
          n_rand++;
        end
        filled = 1'b1;
      end else if (stack_cnt[GEN] > 24) begin
        queue_item(($urandom_range(0, 2) == 0) ? CMD_SHOW : pick_op(), $urandom());
        n_rand++;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            extra = (stack_cnt[GEN] < 2) ? 2 - stack_cnt[GEN] : 0;
            repeat ($urandom_range(extra, extra + 1)) begin
              queue_item(CMD_PUSH, pick_value());
              n_rand++;
            end
            queue_item(pick_op(), $urandom());
            n_rand++;
            if ($urandom_range(0, 2) == 0) begin
              queue_item(CMD_SHOW, $urandom());
              n_rand++;
            end
          end
          6: begin
            queue_item(pick_op(), $urandom());
            n_rand++;
          end
          7: begin
            queue_item(CMD_SHOW, $urandom());
            n_rand++;
          end
          default: begin
            queue_item(cmd_t'($urandom_range(0, 7)), $urandom());
            n_rand++;
          end
        endcase
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || have_item || start || expected_q.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);

    if (fail_count == 0)
      $display("rpn_stack_calculator_top_tb OK");
    else
      $display("rpn_stack_calculator_top_tb NOT OK");
    $finish;
  end

  initial begin
    #8_400_000;
    $display("rpn_stack_calculator_top_tb NOT OK");
    $finish;
  end

endmodule
